/* rtl/vti_pkg.sv */
// Package: shared types, constants and the breakpoint table contents.
`timescale 1ns / 1ps
package vti_pkg;

  localparam int VOLT_W = 22;
  localparam int TEMP_W = 16;
  localparam int OUT_W  = 15;
  localparam int FRAC_W = 16;
  localparam int TBL_SIZE = 48;

  localparam logic [1:0] ST_INSIDE = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;

  typedef struct packed {
    logic        [VOLT_W-1:0] volt;
    logic signed [TEMP_W-1:0] temp;
  } bp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // breakpoint contents: voltage in uV, temperature in Q8.8
  function automatic bp_t rom_word(input logic [7:0] idx);
    bp_t r;
    case (idx)
      8'd0:  r = {22'd950996,  -16'sd1};
      8'd1:  r = {22'd988555,  16'sd255};
      8'd2:  r = {22'd1026863, 16'sd511};
      8'd3:  r = {22'd1065891, 16'sd767};
      8'd4:  r = {22'd1105610, 16'sd1023};
      8'd5:  r = {22'd1145987, 16'sd1279};
      8'd6:  r = {22'd1186987, 16'sd1535};
      8'd7:  r = {22'd1228574, 16'sd1791};
      8'd8:  r = {22'd1270709, 16'sd2047};
      8'd9:  r = {22'd1313353, 16'sd2303};
      8'd10: r = {22'd1356463, 16'sd2559};
      8'd11: r = {22'd1399996, 16'sd2816};
      8'd12: r = {22'd1443907, 16'sd3072};
      8'd13: r = {22'd1488152, 16'sd3328};
      8'd14: r = {22'd1532684, 16'sd3584};
      8'd15: r = {22'd1577456, 16'sd3840};
      8'd16: r = {22'd1622421, 16'sd4096};
      8'd17: r = {22'd1667530, 16'sd4352};
      8'd18: r = {22'd1712738, 16'sd4608};
      8'd19: r = {22'd1757995, 16'sd4864};
      8'd20: r = {22'd1803255, 16'sd5120};
      8'd21: r = {22'd1848472, 16'sd5376};
      8'd22: r = {22'd1893599, 16'sd5632};
      8'd23: r = {22'd1938592, 16'sd5888};
      8'd24: r = {22'd1983406, 16'sd6144};
      8'd25: r = {22'd2028000, 16'sd6400};
      8'd26: r = {22'd2072331, 16'sd6656};
      8'd27: r = {22'd2116361, 16'sd6912};
      8'd28: r = {22'd2160050, 16'sd7168};
      8'd29: r = {22'd2203362, 16'sd7424};
      8'd30: r = {22'd2246264, 16'sd7680};
      8'd31: r = {22'd2288720, 16'sd7936};
      8'd32: r = {22'd2330702, 16'sd8192};
      8'd33: r = {22'd2372180, 16'sd8448};
      8'd34: r = {22'd2413127, 16'sd8704};
      8'd35: r = {22'd2453517, 16'sd8960};
      8'd36: r = {22'd2493329, 16'sd9216};
      8'd37: r = {22'd2532541, 16'sd9472};
      8'd38: r = {22'd2571135, 16'sd9728};
      8'd39: r = {22'd2609093, 16'sd9984};
      8'd40: r = {22'd2646401, 16'sd10240};
      8'd41: r = {22'd2683045, 16'sd10496};
      8'd42: r = {22'd2719014, 16'sd10752};
      8'd43: r = {22'd2754299, 16'sd11008};
      8'd44: r = {22'd2788892, 16'sd11265};
      8'd45: r = {22'd2822788, 16'sd11521};
      8'd46: r = {22'd2855981, 16'sd11777};
      default: r = {22'd2888470, 16'sd12033};
    endcase
    return r;
  endfunction

endpackage

/* rtl/vti_rom.sv */
// Breakpoint ROM with registered read data.
`timescale 1ns / 1ps
module vti_rom
  import vti_pkg::*;
#(
  parameter int DEPTH = TBL_SIZE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output bp_t           rd_data
);

  bp_t rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= rom_word(8'(rd_addr));
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/vti_div.sv */
// Restoring divider: 16 quotient bits of (num << 16) / den, one bit a cycle.
`timescale 1ns / 1ps
module vti_div
  import vti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VOLT_W-1:0] num,
  input  logic [VOLT_W-1:0] den,
  output logic [FRAC_W-1:0] quo,
  output div_stat_t         stat
);

  localparam int CW = $clog2(FRAC_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [VOLT_W-1:0] rem_r;
  logic [VOLT_W-1:0] den_r;
  logic [FRAC_W-1:0] q_r;

  logic [VOLT_W:0]   rem2;
  logic              ge;
  logic [VOLT_W-1:0] rem_nxt;

  // num < den always, so the remainder fits VOLT_W bits
  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = (rem2 >= {1'b0, den_r});
    rem_nxt = ge ? VOLT_W'(rem2 - {1'b0, den_r}) : rem2[VOLT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(FRAC_W - 1);
        rem_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[FRAC_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/voltage_to_temperature_interp.sv */
// Top level: voltage to Q7.8 temperature by piecewise linear table interpolation.
`timescale 1ns / 1ps
// Usage:
//   A request is taken at a rising edge with start high and busy low; it
//   carries in_voltage_uv (microvolts, unsigned). busy stays high while the
//   request is worked on. Exactly one result follows: out_temperature_q8
//   (signed Q7.8) and out_clamp_status (inside / below / above), shown for
//   one cycle with out_valid high. The receiver cannot stall; the result
//   register holds until the next result, and a new request may be taken
//   in the cycle the strobe is high.
//   Sequence: the breakpoint ROM is read one entry a cycle (one read port,
//   registered read data), walking the segments in order. Below-table inputs
//   finish once the first entry is checked. A hit in segment k runs the
//   search, then the bit-serial divider (one quotient bit a cycle), then
//   multiply and round. Inputs past the table finish when the last entry
//   is checked. The default table has 48 entries; one request at a time.
//   Reset (rst_n low, synchronous) returns to idle and drops the strobe;
//   the ROM needs no initialization.
module voltage_to_temperature_interp
  import vti_pkg::*;
#(
  parameter int TABLE_SIZE = TBL_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [VOLT_W-1:0]       in_voltage_uv,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_temperature_q8,
  output logic [1:0]              out_clamp_status
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam bp_t FIRST_BP = rom_word(8'd0);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_FIRST, S_SCAN, S_DIV, S_MUL, S_SUM
  } state_t;

  state_t                   state_r;
  logic [IDX_W-1:0]         addr_r;    // ROM read address
  logic [IDX_W-1:0]         idx_r;     // index of entry now on rd_data
  logic [VOLT_W-1:0]        x_r;
  bp_t                      prev_r;    // lower breakpoint of the segment
  logic [VOLT_W-1:0]        num_r;
  logic [VOLT_W-1:0]        span_r;
  logic                     div_start_r;
  logic signed [TEMP_W:0]   dt_r;
  logic signed [TEMP_W-1:0] t0_r;
  logic [FRAC_W-1:0]        frac_r;
  logic signed [2*TEMP_W+1:0] prod_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_temp_r;
  logic [1:0]               out_stat_r;

  bp_t                      rd_data;
  logic [FRAC_W-1:0]        quo;
  div_stat_t                div_stat;

  logic                     seg_hit;
  logic signed [2*TEMP_W+1:0] rnd;
  logic signed [TEMP_W+2:0] sum;
  logic signed [OUT_W-1:0]  sat;

  vti_rom #(
    .DEPTH (TABLE_SIZE),
    .AW    (IDX_W)
  ) u_rom (
    .clk     (clk),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  vti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (num_r),
    .den   (span_r),
    .quo   (quo),
    .stat  (div_stat)
  );

  // half-open segment [prev, cur): lower end included
  assign seg_hit = (prev_r.volt <= x_r) && (x_r < rd_data.volt);

  // round half up, floor shift, then saturate to the output range
  always_comb begin
    rnd = prod_r + (2*TEMP_W+2)'(32768);
    sum = (TEMP_W+3)'(t0_r) + (TEMP_W+3)'($signed(rnd[2*TEMP_W+1:FRAC_W]));
    if (sum > (TEMP_W+3)'(16383)) begin
      sat = OUT_W'(16383);
    end else if (sum < -(TEMP_W+3)'(16384)) begin
      sat = OUT_W'(-16384);
    end else begin
      sat = sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            x_r     <= in_voltage_uv;
            addr_r  <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          addr_r  <= IDX_W'(1);
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          if (x_r < rd_data.volt) begin
            out_temp_r  <= rd_data.temp[OUT_W-1:0];
            out_stat_r  <= ST_BELOW;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            prev_r  <= rd_data;
            idx_r   <= IDX_W'(1);
            addr_r  <= IDX_W'(2);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (seg_hit) begin
            num_r       <= x_r - prev_r.volt;
            span_r      <= rd_data.volt - prev_r.volt;
            t0_r        <= prev_r.temp;
            dt_r        <= (TEMP_W+1)'(rd_data.temp) - (TEMP_W+1)'(prev_r.temp);
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end else if (idx_r == IDX_W'(TABLE_SIZE - 1)) begin
            // past the last segment: exact last breakpoint is inside
            out_temp_r  <= rd_data.temp[OUT_W-1:0];
            out_stat_r  <= (x_r == rd_data.volt) ? ST_INSIDE : ST_ABOVE;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            prev_r <= rd_data;
            idx_r  <= idx_r + 1'b1;
            addr_r <= addr_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            frac_r  <= quo;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= dt_r * $signed({1'b0, frac_r});
          state_r <= S_SUM;
        end
        S_SUM: begin
          out_temp_r  <= sat;
          out_stat_r  <= ST_INSIDE;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_temperature_q8 = out_temp_r;
  assign out_clamp_status   = out_stat_r;

  // a result only ends a request that was in flight
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  // leaving busy always comes with a result
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("request dropped without a result");

  // below-table clamp gives the first table temperature
  a_below_first_temp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamp_status == ST_BELOW) |->
      (out_temperature_q8 == FIRST_BP.temp[OUT_W-1:0]))
    else $error("below-table clamp value wrong");

  // the divider is never started while still running
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
